/* rtl/qrs_pkg.sv */
// shared types and constants of the quadratic root solver
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;

   localparam int ROOT_WIDTH   = 34;
   localparam int STATUS_WIDTH = 2;
   localparam int QUEUE_DEPTH  = 8;

   localparam logic [STATUS_WIDTH-1:0] ST_NO_ROOTS = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_REPEATED = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_DISTINCT = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_A_ZERO   = 2'd3;

   // classification that travels with each item from front to back
   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic                    neg_a;
      logic                    neg_b;
   } qrs_flags_type;

endpackage
`default_nettype wire

/* rtl/qrs_front.sv */
// front end: magnitudes, products, discriminant and classification
`timescale 1ns / 1ps
`default_nettype none
module qrs_front import qrs_pkg::*; #(
   parameter int COEF_WIDTH = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire logic [COEF_WIDTH-1:0]   in_a,
   input  wire logic [COEF_WIDTH-1:0]   in_b,
   input  wire logic [COEF_WIDTH-1:0]   in_c,
   output logic [2:0]                   busy,
   output logic                         out_valid,
   output qrs_flags_type                out_flags,
   output logic [2*COEF_WIDTH:0]        out_disc,
   output logic [COEF_WIDTH-1:0]        out_mag_a,
   output logic [COEF_WIDTH-1:0]        out_mag_b
);

   localparam int CW = COEF_WIDTH;
   localparam int DW = 2 * CW + 1;

   logic          v1_ff, v2_ff, v3_ff;
   logic [CW-1:0] a1_ff, b1_ff, c1_ff;

   logic          na, nb, nc;
   logic [CW-1:0] ma, mb, mc;

   logic          na2_ff, nb2_ff, nc2_ff;
   logic [CW-1:0] ma2_ff, mb2_ff;
   logic [2*CW-1:0] b2_ff, q_ff;

   logic [2*CW+1:0] q4, b2x, dsum, ddif;
   qrs_flags_type   fl_in, fl3_ff;
   logic [DW-1:0]   d_in, d3_ff;
   logic [CW-1:0]   ma3_ff, mb3_ff;

   assign na = a1_ff[CW-1];
   assign nb = b1_ff[CW-1];
   assign nc = c1_ff[CW-1];
   assign ma = na ? (~a1_ff + 1'b1) : a1_ff;
   assign mb = nb ? (~b1_ff + 1'b1) : b1_ff;
   assign mc = nc ? (~c1_ff + 1'b1) : c1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      a1_ff  <= in_a;
      b1_ff  <= in_b;
      c1_ff  <= in_c;
      na2_ff <= na;
      nb2_ff <= nb;
      nc2_ff <= nc;
      ma2_ff <= ma;
      mb2_ff <= mb;
      b2_ff  <= mb * mb;
      q_ff   <= ma * mc;
      fl3_ff <= fl_in;
      d3_ff  <= d_in;
      ma3_ff <= ma2_ff;
      mb3_ff <= mb2_ff;
   end

   assign q4   = {q_ff, 2'b00};
   assign b2x  = {2'b00, b2_ff};
   assign dsum = b2x + q4;
   assign ddif = b2x - q4;

   // opposite signs of a and c add to the discriminant
   always_comb begin
      fl_in.neg_a = na2_ff;
      fl_in.neg_b = nb2_ff;
      priority if (ma2_ff == '0) begin
         fl_in.status = ST_A_ZERO;
         d_in         = '0;
      end else if ((q_ff != '0) && (na2_ff != nc2_ff)) begin
         fl_in.status = ST_DISTINCT;
         d_in         = dsum[DW-1:0];
      end else if (b2x < q4) begin
         fl_in.status = ST_NO_ROOTS;
         d_in         = '0;
      end else if (b2x == q4) begin
         fl_in.status = ST_REPEATED;
         d_in         = '0;
      end else begin
         fl_in.status = ST_DISTINCT;
         d_in         = ddif[DW-1:0];
      end
   end

   assign busy      = {v3_ff, v2_ff, v1_ff};
   assign out_valid = v3_ff;
   assign out_flags = fl3_ff;
   assign out_disc  = d3_ff;
   assign out_mag_a = ma3_ff;
   assign out_mag_b = mb3_ff;

endmodule
`default_nettype wire

/* rtl/qrs_queue.sv */
// small first-in first-out queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module qrs_queue import qrs_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   input  wire logic [WIDTH-1:0]               push_data,
   input  wire logic                           pop,
   output logic                                head_valid,
   output logic [WIDTH-1:0]                    head_data,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]    count
);

   localparam int AW = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0] entry_ff [0:QUEUE_DEPTH-1];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] cnt_ff, cnt_in;

   assign wr_in  = push ? wr_ff + 1'b1 : wr_ff;
   assign rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
   assign cnt_in = cnt_ff + {{($bits(cnt_ff)-1){1'b0}}, push}
                          - {{($bits(cnt_ff)-1){1'b0}}, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

   assign head_valid = (cnt_ff != '0);
   assign head_data  = entry_ff[rd_ff];
   assign count      = cnt_ff;

endmodule
`default_nettype wire

/* rtl/qrs_back.sv */
// back end: pipelined square root, two pipelined dividers, output register
`timescale 1ns / 1ps
`default_nettype none
module qrs_back import qrs_pkg::*; #(
   parameter int COEF_WIDTH    = 16,
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire qrs_flags_type             in_flags,
   input  wire logic [2*COEF_WIDTH:0]     in_disc,
   input  wire logic [COEF_WIDTH-1:0]     in_mag_a,
   input  wire logic [COEF_WIDTH-1:0]     in_mag_b,
   output logic                           in_pop,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output logic [STATUS_WIDTH-1:0]        out_status,
   output logic [ROOT_WIDTH-1:0]          out_plus,
   output logic [ROOT_WIDTH-1:0]          out_minus
);

   localparam int CW   = COEF_WIDTH;
   localparam int F    = FRACTION_BITS;
   localparam int DW   = 2 * CW + 1;
   localparam int RW   = DW + 2 * F;
   localparam int SW   = (RW + 1) / 2;
   localparam int REMW = SW + 3;
   localparam int NW   = ((CW - 1 + F) > SW ? (CW - 1 + F) : SW) + 2;
   localparam int DENW = CW + 1;
   localparam int XW   = (NW > ROOT_WIDTH ? NW : ROOT_WIDTH) + 1;

   logic en;

   // square root stages
   logic            s_v_ff    [0:SW];
   qrs_flags_type   s_fl_ff   [0:SW];
   logic [2*SW-1:0] s_rad_ff  [0:SW];
   logic [REMW-1:0] s_rem_ff  [0:SW];
   logic [SW-1:0]   s_root_ff [0:SW];
   logic [CW-1:0]   s_ma_ff   [0:SW];
   logic [CW-1:0]   s_mb_ff   [0:SW];

   // divider stages, lane 0 plus root, lane 1 minus root
   logic            d_v_ff    [0:NW];
   qrs_flags_type   d_fl_ff   [0:NW];
   logic [DENW-1:0] d_den_ff  [0:NW];
   logic [NW-1:0]   d_num_ff  [0:NW][0:1];
   logic [NW-1:0]   d_q_ff    [0:NW][0:1];
   logic [DENW-1:0] d_rem_ff  [0:NW][0:1];
   logic            d_neg_ff  [0:NW][0:1];

   logic                    out_v_ff;
   logic [STATUS_WIDTH-1:0] out_st_ff;
   logic [ROOT_WIDTH-1:0]   out_p_ff, out_m_ff;

   assign en     = !out_v_ff || out_ready;
   assign in_pop = en && in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_v_ff[0] <= 1'b0;
      end else if (en) begin
         s_v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_fl_ff[0]   <= in_flags;
         s_rad_ff[0]  <= {{(2*SW-RW){1'b0}}, in_disc, {(2*F){1'b0}}};
         s_rem_ff[0]  <= '0;
         s_root_ff[0] <= '0;
         s_ma_ff[0]   <= in_mag_a;
         s_mb_ff[0]   <= in_mag_b;
      end
   end

   // one root bit per stage from the top bit pair down
   for (genvar k = 0; k < SW; k++) begin : g_sqrt
      logic [REMW-1:0] sh, tr, rem_in;
      logic [SW-1:0]   root_in;
      logic            ge;

      assign sh      = {s_rem_ff[k][REMW-3:0], s_rad_ff[k][2*SW-1 -: 2]};
      assign tr      = {1'b0, s_root_ff[k], 2'b01};
      assign ge      = (sh >= tr);
      assign rem_in  = ge ? (sh - tr) : sh;
      assign root_in = {s_root_ff[k][SW-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            s_v_ff[k+1] <= 1'b0;
         end else if (en) begin
            s_v_ff[k+1] <= s_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            s_fl_ff[k+1]   <= s_fl_ff[k];
            s_rad_ff[k+1]  <= {s_rad_ff[k][2*SW-3:0], 2'b00};
            s_rem_ff[k+1]  <= rem_in;
            s_root_ff[k+1] <= root_in;
            s_ma_ff[k+1]   <= s_ma_ff[k];
            s_mb_ff[k+1]   <= s_mb_ff[k];
         end
      end
   end

   // numerators -b*2^F plus and minus the root, split into sign and magnitude
   logic [NW-1:0] negb_mag, negb, s_ext, num_p, num_m;

   assign negb_mag = {{(NW-CW-F){1'b0}}, s_mb_ff[SW], {F{1'b0}}};
   assign negb     = s_fl_ff[SW].neg_b ? negb_mag : (~negb_mag + 1'b1);
   assign s_ext    = {{(NW-SW){1'b0}}, s_root_ff[SW]};
   assign num_p    = negb + s_ext;
   assign num_m    = negb - s_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff[0] <= 1'b0;
      end else if (en) begin
         d_v_ff[0] <= s_v_ff[SW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_fl_ff[0]     <= s_fl_ff[SW];
         d_den_ff[0]    <= {s_ma_ff[SW], 1'b0};
         d_num_ff[0][0] <= num_p[NW-1] ? (~num_p + 1'b1) : num_p;
         d_num_ff[0][1] <= num_m[NW-1] ? (~num_m + 1'b1) : num_m;
         d_neg_ff[0][0] <= num_p[NW-1] ^ s_fl_ff[SW].neg_a;
         d_neg_ff[0][1] <= num_m[NW-1] ^ s_fl_ff[SW].neg_a;
         d_q_ff[0][0]   <= '0;
         d_q_ff[0][1]   <= '0;
         d_rem_ff[0][0] <= '0;
         d_rem_ff[0][1] <= '0;
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar j = 0; j < NW; j++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) begin
            d_v_ff[j+1] <= 1'b0;
         end else if (en) begin
            d_v_ff[j+1] <= d_v_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            d_fl_ff[j+1]  <= d_fl_ff[j];
            d_den_ff[j+1] <= d_den_ff[j];
         end
      end

      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [DENW:0] sh, diff;
         logic          ge;

         assign sh   = {d_rem_ff[j][l], d_num_ff[j][l][NW-1]};
         assign diff = sh - {1'b0, d_den_ff[j]};
         assign ge   = (sh >= {1'b0, d_den_ff[j]});

         always_ff @(posedge clock) begin
            if (en) begin
               d_num_ff[j+1][l] <= {d_num_ff[j][l][NW-2:0], 1'b0};
               d_q_ff[j+1][l]   <= {d_q_ff[j][l][NW-2:0], ge};
               d_rem_ff[j+1][l] <= ge ? diff[DENW-1:0] : sh[DENW-1:0];
               d_neg_ff[j+1][l] <= d_neg_ff[j][l];
            end
         end
      end
   end

   logic [XW-1:0] qp_x, qm_x, rp_x, rm_x;
   logic          zero_roots;

   assign qp_x = {{(XW-NW){1'b0}}, d_q_ff[NW][0]};
   assign qm_x = {{(XW-NW){1'b0}}, d_q_ff[NW][1]};
   assign rp_x = d_neg_ff[NW][0] ? (~qp_x + 1'b1) : qp_x;
   assign rm_x = d_neg_ff[NW][1] ? (~qm_x + 1'b1) : qm_x;
   assign zero_roots = (d_fl_ff[NW].status == ST_NO_ROOTS) ||
                       (d_fl_ff[NW].status == ST_A_ZERO);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= d_v_ff[NW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_st_ff <= d_fl_ff[NW].status;
         out_p_ff  <= zero_roots ? '0 : rp_x[ROOT_WIDTH-1:0];
         out_m_ff  <= zero_roots ? '0 : rm_x[ROOT_WIDTH-1:0];
      end
   end

   assign out_valid  = out_v_ff;
   assign out_status = out_st_ff;
   assign out_plus   = out_p_ff;
   assign out_minus  = out_m_ff;

endmodule
`default_nettype wire

/* rtl/quadratic_root_solver_core.sv */
// top level of the quadratic root solver
// pipeline: 75 register stages at the default widths, 3 front, 1 queue,
//   COEF_WIDTH+FRACTION_BITS+2 square root, COEF_WIDTH+FRACTION_BITS+4 divide and 1 output
// throughput: one beat per cycle while rsp_tready is high and the queue has room;
//   every square root bit and quotient bit has its own stage
// reset: synchronous, active high; clears all valid flags and the queue, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module quadratic_root_solver_core import qrs_pkg::*; #(
   parameter int COEF_WIDTH    = 16,
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // coef_a, coef_b, coef_c from the lowest bit up, zero padded to bytes
   input  wire logic [((3*COEF_WIDTH+7)/8)*8-1:0]      req_tdata,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // root_plus, root_minus from the lowest bit up, zero padded to bytes
   output logic [((2*ROOT_WIDTH+7)/8)*8-1:0]           rsp_tdata,
   // root_status
   output logic [STATUS_WIDTH-1:0]                     rsp_tuser,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready
);

   localparam int CW   = COEF_WIDTH;
   localparam int DW   = 2 * CW + 1;
   localparam int QW   = $bits(qrs_flags_type) + DW + 2 * CW;
   localparam int OUTW = ((2 * ROOT_WIDTH + 7) / 8) * 8;

   logic [2:0]    fr_busy;
   logic          fr_valid;
   qrs_flags_type fr_flags, q_flags;
   logic [DW-1:0] fr_disc, q_disc;
   logic [CW-1:0] fr_ma, fr_mb, q_ma, q_mb;
   logic          q_valid, q_pop;
   logic [QW-1:0] q_head;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
   logic [$clog2(QUEUE_DEPTH+1):0]   committed;
   logic          req_beat;

   logic [STATUS_WIDTH-1:0] bk_status;
   logic [ROOT_WIDTH-1:0]   bk_plus, bk_minus;

   // front items are in flight without stalling, so count them against queue room
   assign committed  = {1'b0, q_count} + {{($bits(committed)-1){1'b0}}, fr_busy[0]}
                     + {{($bits(committed)-1){1'b0}}, fr_busy[1]}
                     + {{($bits(committed)-1){1'b0}}, fr_busy[2]};
   assign req_tready = (committed < ($bits(committed))'(QUEUE_DEPTH));
   assign req_beat   = req_tvalid && req_tready;

   qrs_front #(
      .COEF_WIDTH (COEF_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_beat),
      .in_a      (req_tdata[CW-1:0]),
      .in_b      (req_tdata[2*CW-1:CW]),
      .in_c      (req_tdata[3*CW-1:2*CW]),
      .busy      (fr_busy),
      .out_valid (fr_valid),
      .out_flags (fr_flags),
      .out_disc  (fr_disc),
      .out_mag_a (fr_ma),
      .out_mag_b (fr_mb)
   );

   qrs_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (fr_valid),
      .push_data  ({fr_flags, fr_disc, fr_ma, fr_mb}),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head),
      .count      (q_count)
   );

   assign {q_flags, q_disc, q_ma, q_mb} = q_head;

   qrs_back #(
      .COEF_WIDTH    (COEF_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_valid),
      .in_flags   (q_flags),
      .in_disc    (q_disc),
      .in_mag_a   (q_ma),
      .in_mag_b   (q_mb),
      .in_pop     (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_status (bk_status),
      .out_plus   (bk_plus),
      .out_minus  (bk_minus)
   );

   assign rsp_tuser = bk_status;
   assign rsp_tdata = {{(OUTW-2*ROOT_WIDTH){1'b0}}, bk_minus, bk_plus};

endmodule
`default_nettype wire

/* rtl/qrs_checker.sv */
// port checker for the quadratic root solver and its bind
`timescale 1ns / 1ps
`default_nettype none
module qrs_checker import qrs_pkg::*; (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic [((2*ROOT_WIDTH+7)/8)*8-1:0]    rsp_tdata,
   input wire logic [STATUS_WIDTH-1:0]              rsp_tuser,
   input wire logic                                 rsp_tvalid,
   input wire logic                                 rsp_tready
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   a_zero_roots: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_NO_ROOTS || rsp_tuser == ST_A_ZERO)
      |-> rsp_tdata[2*ROOT_WIDTH-1:0] == '0)
      else $error("roots not zero without real roots");

   a_repeated: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_REPEATED
      |-> rsp_tdata[ROOT_WIDTH-1:0] == rsp_tdata[2*ROOT_WIDTH-1:ROOT_WIDTH])
      else $error("repeated root differs between lanes");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

endmodule

bind quadratic_root_solver_core qrs_checker u_qrs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
`default_nettype wire

/* sim/tb_top.sv */
// self-checking testbench of the quadratic root solver core
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import qrs_pkg::*;

   localparam int CW       = 16;
   localparam int FB       = 16;
   localparam int IN_W     = ((3*CW+7)/8)*8;
   localparam int OUT_W    = ((2*ROOT_WIDTH+7)/8)*8;
   localparam int N_RANDOM = 1650;
   localparam int DRAIN    = 200;

   typedef struct {
      logic [STATUS_WIDTH-1:0] status;
      logic [ROOT_WIDTH-1:0]   plus;
      logic [ROOT_WIDTH-1:0]   minus;
   } roots_type;

   // one directed row: coefficients, and a typed-in answer where obvious
   typedef struct {
      logic signed [CW-1:0]    a;
      logic signed [CW-1:0]    b;
      logic signed [CW-1:0]    c;
      bit                      fixed;
      logic [STATUS_WIDTH-1:0] status;
      logic [ROOT_WIDTH-1:0]   plus;
      logic [ROOT_WIDTH-1:0]   minus;
   } row_type;

   logic              clock;
   logic              reset;
   logic [IN_W-1:0]   req_tdata;
   logic              req_tvalid;
   wire logic         req_tready;
   wire logic [OUT_W-1:0] rsp_tdata;
   wire logic [STATUS_WIDTH-1:0] rsp_tuser;
   wire logic         rsp_tvalid;
   logic              rsp_tready;

   roots_type pending_roots[$];
   int        n_errors;
   bit        calm;

   quadratic_root_solver_core #(.COEF_WIDTH(CW), .FRACTION_BITS(FB)) DUT (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // floor square root of a non-negative value, bit by bit
   function automatic longint unsigned isqrt(logic [127:0] v);
      logic [63:0]  r;
      logic [63:0]  t;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         t = r | (64'd1 << i);
         if (128'(t) * 128'(t) <= v) r = t;
      end
      return r;
   endfunction

   // expected roots of a*x^2+b*x+c, division truncated toward zero
   function automatic roots_type solve_roots(logic signed [CW-1:0] a,
                                             logic signed [CW-1:0] b,
                                             logic signed [CW-1:0] c);
      roots_type r;
      logic signed [127:0] disc;
      logic signed [127:0] negb;
      logic signed [127:0] s;
      logic signed [127:0] den;
      r.status = ST_NO_ROOTS;
      r.plus   = '0;
      r.minus  = '0;
      if (a == 0) begin
         r.status = ST_A_ZERO;
         return r;
      end
      disc = 128'(b) * 128'(b) - 128'sd4 * 128'(a) * 128'(c);
      if (disc < 0) return r;
      r.status = (disc == 0) ? ST_REPEATED : ST_DISTINCT;
      s    = (disc == 0) ? 128'sd0 : 128'(isqrt(disc << (2*FB)));
      negb = -(128'(b) <<< FB);
      den  = 128'sd2 * 128'(a);
      // systemverilog signed division already truncates toward zero
      r.plus  = ROOT_WIDTH'((negb + s) / den);
      r.minus = ROOT_WIDTH'((negb - s) / den);
      return r;
   endfunction

   // one beat on the request side, with random gaps; valid stays up for the next beat
   task automatic send_coefs(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                             logic signed [CW-1:0] c, roots_type want);
      while (!calm && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= IN_W'({c, b, a});
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_roots.push_back(want);
      @(negedge clock);
   endtask

   // result side: random stalls, compare each beat with the oldest answer
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else       rsp_tready <= calm || ($urandom_range(99) >= 12);
   end

   always @(posedge clock) begin
      roots_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_roots.size() == 0) begin
            $error("unexpected result beat");
            n_errors++;
         end else begin
            w = pending_roots.pop_front();
            if (rsp_tuser !== w.status) begin
               $error("root_status expected %0d actual %0d", w.status, rsp_tuser);
               n_errors++;
            end
            if (rsp_tdata[ROOT_WIDTH-1:0] !== w.plus) begin
               $error("root_plus expected %h actual %h", w.plus,
                      rsp_tdata[ROOT_WIDTH-1:0]);
               n_errors++;
            end
            if (rsp_tdata[2*ROOT_WIDTH-1:ROOT_WIDTH] !== w.minus) begin
               $error("root_minus expected %h actual %h", w.minus,
                      rsp_tdata[2*ROOT_WIDTH-1:ROOT_WIDTH]);
               n_errors++;
            end
            if (rsp_tdata[OUT_W-1:2*ROOT_WIDTH] !== '0) begin
               $error("padding expected 0 actual %h", rsp_tdata[OUT_W-1:2*ROOT_WIDTH]);
               n_errors++;
            end
         end
      end
   end

   // directed rows; answers typed in only for zero a, plain cases and no roots
   row_type plan[] = '{
      '{16'sd0,      16'sd5,      16'sd7,      1, ST_A_ZERO,   '0, '0},
      '{16'sd0,      -16'sd32768, 16'sd32767,  1, ST_A_ZERO,   '0, '0},
      '{16'sd1,      16'sd0,      16'sd1,      1, ST_NO_ROOTS, '0, '0},
      '{16'sd1,      16'sd0,      16'sd0,      1, ST_REPEATED, '0, '0},
      '{16'sd1,      -16'sd2,     16'sd1,      1, ST_REPEATED, 34'h10000, 34'h10000},
      '{16'sd1,      16'sd0,      -16'sd1,     1, ST_DISTINCT, 34'h10000, 34'h3FFFF0000},
      '{16'sd32767,  16'sd0,      16'sd32767,  1, ST_NO_ROOTS, '0, '0},
      '{-16'sd32768, 16'sd0,      -16'sd32768, 1, ST_NO_ROOTS, '0, '0},
      '{16'sd1,      -16'sd32768, -16'sd32768, 0, '0, '0, '0},
      '{16'sd1,      16'sd32767,  16'sd32767,  0, '0, '0, '0},
      '{-16'sd1,     -16'sd32768, 16'sd32767,  0, '0, '0, '0},
      '{-16'sd32768, 16'sd32767,  16'sd32767,  0, '0, '0, '0},
      '{16'sd32767,  -16'sd32768, -16'sd32768, 0, '0, '0, '0},
      '{-16'sd32768, -16'sd32768, 16'sd32767,  0, '0, '0, '0},
      '{16'sd1,      16'sd3,      16'sd2,      0, '0, '0, '0},
      '{16'sd3,      16'sd7,      -16'sd5,     0, '0, '0, '0},
      '{-16'sd7,     16'sd3,      16'sd11,     0, '0, '0, '0},
      '{16'sd2,      16'sd3,      16'sd0,      0, '0, '0, '0},
      '{-16'sd4,     16'sd4,      -16'sd1,     0, '0, '0, '0},
      '{16'sd9,      -16'sd6,     16'sd1,      0, '0, '0, '0}
   };

   initial begin
      roots_type want;
      logic signed [CW-1:0] a, b, c;
      int guard;
      n_errors   = 0;
      calm       = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) begin
         if (plan[i].fixed) begin
            want.status = plan[i].status;
            want.plus   = plan[i].plus;
            want.minus  = plan[i].minus;
         end else begin
            want = solve_roots(plan[i].a, plan[i].b, plan[i].c);
         end
         send_coefs(plan[i].a, plan[i].b, plan[i].c, want);
      end
      req_tvalid <= 1'b0;

      // hold off until the pipe has fully drained
      while (pending_roots.size() != 0) @(negedge clock);

      for (int n = 0; n < N_RANDOM; n++) begin
         calm = (n >= 600 && n < 800);
         a = CW'($urandom);
         b = CW'($urandom);
         c = CW'($urandom);
         case ($urandom_range(7))
            0: a = CW'($urandom_range(3) - 1);       // around zero a
            1: begin                                 // perfect square: repeated root, no roots when b is zero
               b = CW'(2 * $urandom_range(60));
               a = CW'((b * b) / 4);
               c = 16'sd1;
               if (a == 0) a = 16'sd1;
            end
            2: begin
               a = CW'($signed(16'($urandom_range(255))) - 128);
               c = CW'($urandom_range(255));
            end
            3: begin b = CW'($urandom_range(15)); c = CW'(-$urandom_range(15)); end
            default: ;
         endcase
         send_coefs(a, b, c, solve_roots(a, b, c));
      end
      req_tvalid <= 1'b0;
      calm = 1'b0;

      guard = 0;
      while (pending_roots.size() != 0 && guard < 100000) begin
         @(negedge clock);
         guard++;
      end
      repeat (DRAIN) @(negedge clock);

      if (n_errors == 0 && pending_roots.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
